FILE: hdl/slab_object_allocator_core_assert.svh
// Assertion macros for the slab object allocator.
`ifndef SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, gated by reset
`define SOA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated by reset
`define SOA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/soa_pkg.sv
// ----------------------------------------------------------------------------
// soa_pkg
// Widths, codes and helpers shared by the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

	localparam int NUM_SLABS = 16;
	localparam int MAX_SLOTS = 64;
	localparam int SLAB_W    = $clog2(NUM_SLABS);
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int ADDR_W    = SLAB_W + SLOT_W;
	localparam int CNT_W     = 7;
	localparam int PC_W      = SLAB_W + 1;
	localparam int HANDLE_W  = 10;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		RSP_OK       = 2'd0,
		RSP_NO_SLABS = 2'd1,
		RSP_BAD_FREE = 2'd2
	} rsp_code_t;

	typedef enum logic [1:0] {
		ST_POOL    = 2'd0,
		ST_PARTIAL = 2'd1,
		ST_FULL    = 2'd2,
		ST_CACHE   = 2'd3
	} slab_st_t;

	// Clamp slots per slab into 1..MAX_SLOTS
	function automatic logic [CNT_W-1:0] eff_slots(input logic [CNT_W-1:0] raw);
		logic [CNT_W-1:0] n;
		n = raw;
		if (n == '0) n = CNT_W'(1);
		if (n > CNT_W'(MAX_SLOTS)) n = CNT_W'(MAX_SLOTS);
		return n;
	endfunction

endpackage

FILE: hdl/soa_if.sv
// ----------------------------------------------------------------------------
// soa_req_if / soa_rsp_if / soa_cfg_if
// Valid/ready channels of the slab object allocator.
// ----------------------------------------------------------------------------
interface soa_req_if;
	import soa_pkg::*;
	logic                valid;
	logic                ready;
	logic                operation;
	logic [HANDLE_W-1:0] free_handle;
	modport source (output valid, operation, free_handle, input ready);
	modport sink   (input valid, operation, free_handle, output ready);
endinterface

interface soa_rsp_if;
	import soa_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] alloc_handle;
	modport source (output valid, status, alloc_handle, input ready);
	modport sink   (input valid, status, alloc_handle, output ready);
endinterface

interface soa_cfg_if;
	import soa_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/soa_stack_ram.sv
// ----------------------------------------------------------------------------
// soa_stack_ram
// Single-port slot stack memory, registered read data.
// ----------------------------------------------------------------------------
module soa_stack_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [soa_pkg::ADDR_W-1:0] addr,
	input  logic [soa_pkg::SLOT_W-1:0] wdata,
	output logic [soa_pkg::SLOT_W-1:0] rdata
);
	import soa_pkg::*;

	logic [SLOT_W-1:0] mem [NUM_SLABS*MAX_SLOTS];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: hdl/slab_object_allocator_core.sv
// ----------------------------------------------------------------------------
// slab_object_allocator_core
// Allocate/free engine for one object type over per-slab slot stacks.
//
// channel  dir  handshake     payload
// req      in   valid/ready   operation, free_handle
// rsp      out  valid/ready   status, alloc_handle
// cfg      in   valid/ready   data (slots_per_slab)
//
// Allocate from a partial or cached slab: S_POP, S_RD, S_FIN, plus S_LINK
// if the slab runs out. Free: S_LINK, S_FIN, plus S_INSERT when relinked at
// the head; bad_free and out_of_slabs go to S_FIN. A fresh pool slab fills
// slots_per_slab stack entries in S_FILL, one per cycle on the single port.
// Reset clears counts, slab states, list and cache; stack memory is not reset.
// A new request is taken while an earlier result still waits on rsp; the
// next result then holds in S_FIN until that one is accepted.
// ----------------------------------------------------------------------------
module slab_object_allocator_core (
	input logic  clk,
	input logic  arst_n,
	soa_req_if.sink   req,
	soa_rsp_if.source rsp,
	soa_cfg_if.sink   cfg
);
	import soa_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_FILL   = 7'b0000010,
		S_POP    = 7'b0000100,
		S_RD     = 7'b0001000,
		S_LINK   = 7'b0010000,
		S_INSERT = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]    spb_q;
	logic [CNT_W-1:0]    fc_q   [NUM_SLABS];
	slab_st_t            st_q   [NUM_SLABS];
	logic [SLAB_W-1:0]   next_q [NUM_SLABS];
	logic [SLAB_W-1:0]   prev_q [NUM_SLABS];
	logic [SLAB_W-1:0]   head_q;
	logic [PC_W-1:0]     pc_q;
	logic                cache_vld_q;
	logic [SLAB_W-1:0]   cache_q;

	logic [SLAB_W-1:0]   s_q;
	logic [SLOT_W-1:0]   k_q;
	logic [CNT_W-1:0]    nfc_q;
	logic                rm_q;
	logic                ins_q;
	rsp_code_t           res_st_q;
	logic [HANDLE_W-1:0] res_h_q;
	logic                out_vld_q;
	logic [1:0]          out_st_q;
	logic [HANDLE_W-1:0] out_h_q;

	logic [CNT_W-1:0]    spb;
	logic [SLAB_W-1:0]   in_s;
	logic [SLOT_W-1:0]   in_slot;
	logic [CNT_W-1:0]    in_fc;
	logic                free_bad;
	logic                pool_found;
	logic [SLAB_W-1:0]   pool_idx;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [SLOT_W-1:0]   ram_wdata;
	logic [SLOT_W-1:0]   ram_rdata;
	logic [CNT_W-1:0]    pop_fc;
	logic                req_fire;

	assign spb      = eff_slots(spb_q);
	assign in_s     = req.free_handle[ADDR_W-1:SLOT_W];
	assign in_slot  = req.free_handle[SLOT_W-1:0];
	assign in_fc    = fc_q[in_s];
	assign free_bad = !(st_q[in_s] == ST_PARTIAL || st_q[in_s] == ST_FULL) || in_fc >= spb;
	assign pop_fc   = fc_q[s_q] - CNT_W'(1);
	assign req_fire = req.valid && req.ready;

	assign req.ready     = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign rsp.valid     = out_vld_q;
	assign rsp.status    = out_st_q;
	assign rsp.alloc_handle = out_h_q;

	// lowest pool slab
	always_comb begin
		pool_found = 1'b0;
		pool_idx   = '0;
		for (int i = NUM_SLABS - 1; i >= 0; i--) begin
			if (st_q[i] == ST_POOL) begin
				pool_found = 1'b1;
				pool_idx   = SLAB_W'(i);
			end
		end
	end

	// stack memory port
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = {s_q, pop_fc[SLOT_W-1:0]};
		ram_wdata = k_q;
		case (state_q)
			S_IDLE: begin
				ram_addr  = {in_s, in_fc[SLOT_W-1:0]};
				ram_wdata = in_slot;
				ram_we    = req_fire && req.operation == OP_FREE && !free_bad;
			end
			S_FILL: begin
				ram_we   = 1'b1;
				ram_addr = {s_q, k_q};
			end
			default: begin
			end
		endcase
	end

	soa_stack_ram u_stack (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// sequencer and slab bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			spb_q       <= CNT_W'(16);
			head_q      <= '0;
			pc_q        <= '0;
			cache_vld_q <= 1'b0;
			cache_q     <= '0;
			out_vld_q   <= 1'b0;
			rm_q        <= 1'b0;
			ins_q       <= 1'b0;
			for (int i = 0; i < NUM_SLABS; i++) begin
				fc_q[i]   <= '0;
				st_q[i]   <= ST_POOL;
				next_q[i] <= '0;
				prev_q[i] <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				spb_q <= cfg.data;
			end
			// S_FIN reloads the output register itself
			if (rsp.valid && rsp.ready && state_q != S_FIN) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						res_st_q <= RSP_OK;
						res_h_q  <= '0;
						rm_q     <= 1'b0;
						ins_q    <= 1'b0;
						if (req.operation == OP_ALLOC) begin
							if (pc_q != '0) begin
								s_q     <= head_q;
								state_q <= S_POP;
							end else if (cache_vld_q) begin
								s_q           <= cache_q;
								cache_vld_q   <= 1'b0;
								cache_q       <= '0;
								st_q[cache_q] <= ST_PARTIAL;
								next_q[cache_q] <= cache_q;
								prev_q[cache_q] <= cache_q;
								head_q        <= cache_q;
								pc_q          <= PC_W'(1);
								state_q       <= S_POP;
							end else if (pool_found) begin
								s_q     <= pool_idx;
								k_q     <= '0;
								state_q <= S_FILL;
							end else begin
								res_st_q <= RSP_NO_SLABS;
								state_q  <= S_FIN;
							end
						end else if (free_bad) begin
							res_st_q <= RSP_BAD_FREE;
							state_q  <= S_FIN;
						end else begin
							s_q        <= in_s;
							fc_q[in_s] <= in_fc + CNT_W'(1);
							state_q    <= S_LINK;
							if (in_fc == '0) begin
								// was full, or single-slot slab: relink at head
								rm_q       <= (st_q[in_s] == ST_PARTIAL);
								ins_q      <= 1'b1;
								st_q[in_s] <= ST_PARTIAL;
							end else if (in_fc + CNT_W'(1) == spb) begin
								// wholly free: becomes the cache
								rm_q <= 1'b1;
								if (cache_vld_q) begin
									st_q[cache_q] <= ST_POOL;
								end
								cache_q     <= in_s;
								cache_vld_q <= 1'b1;
								st_q[in_s]  <= ST_CACHE;
							end
						end
					end
				end
				S_FILL: begin
					k_q <= k_q + SLOT_W'(1);
					if ({1'b0, k_q} == spb - CNT_W'(1)) begin
						fc_q[s_q]   <= spb;
						st_q[s_q]   <= ST_PARTIAL;
						next_q[s_q] <= s_q;
						prev_q[s_q] <= s_q;
						head_q      <= s_q;
						pc_q        <= PC_W'(1);
						state_q     <= S_POP;
					end
				end
				S_POP: begin
					if (fc_q[s_q] == '0 || fc_q[s_q] > CNT_W'(MAX_SLOTS)) begin
						// defensive: empty selected slab
						rm_q      <= 1'b1;
						st_q[s_q] <= ST_FULL;
						res_st_q  <= RSP_NO_SLABS;
						state_q   <= S_LINK;
					end else begin
						fc_q[s_q] <= pop_fc;
						nfc_q     <= pop_fc;
						state_q   <= S_RD;
					end
				end
				S_RD: begin
					res_h_q <= {s_q, ram_rdata};
					if (nfc_q == '0) begin
						rm_q      <= 1'b1;
						st_q[s_q] <= ST_FULL;
						state_q   <= S_LINK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LINK: begin
					// unlink s_q from the partial list
					if (rm_q && pc_q != '0) begin
						if (pc_q == PC_W'(1)) begin
							head_q <= '0;
						end else begin
							next_q[prev_q[s_q]] <= next_q[s_q];
							prev_q[next_q[s_q]] <= prev_q[s_q];
							if (head_q == s_q) begin
								head_q <= next_q[s_q];
							end
						end
						pc_q <= pc_q - PC_W'(1);
					end
					state_q <= ins_q ? S_INSERT : S_FIN;
				end
				S_INSERT: begin
					// link s_q in as the new head
					if (pc_q == '0) begin
						next_q[s_q] <= s_q;
						prev_q[s_q] <= s_q;
					end else begin
						next_q[prev_q[head_q]] <= s_q;
						prev_q[s_q]            <= prev_q[head_q];
						next_q[s_q]            <= head_q;
						prev_q[head_q]         <= s_q;
					end
					head_q  <= s_q;
					pc_q    <= pc_q + PC_W'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q <= 1'b1;
						out_st_q  <= res_st_q;
						out_h_q   <= res_h_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`include "slab_object_allocator_core_assert.svh"

	`SOA_ASSERT_IMP(a_pc_range, 1'b1, pc_q <= PC_W'(NUM_SLABS), "partial count overflow")
	`SOA_ASSERT_IMP(a_cache_state, cache_vld_q, st_q[cache_q] == ST_CACHE, "cache slab state")
	`SOA_ASSERT_IMP(a_empty_head, pc_q == '0, head_q == '0, "head not cleared on empty list")

endmodule
